// File: sv/obrf_pkg.sv
// Shared types, constants and a helper function for the overwrite byte ring FIFO.
package obrf_pkg;

    // Field widths of the beats and of the capacity register.
    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 9;
    localparam int BYTE_W  = 8;

    // Default store depth and the capacity value after reset.
    localparam int DEPTH_DEFAULT = 256;
    localparam int CAP_RESET     = 256;

    // ASCII constants for hex decoding.
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] LA_OFS   = 8'h57;
    localparam logic [BYTE_W-1:0] UA_OFS   = 8'h37;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FN_WR8  = 3'd0,
        FN_WR16 = 3'd1,
        FN_WR32 = 3'd2,
        FN_RD8  = 3'd3,
        FN_RD16 = 3'd4,
        FN_RD32 = 3'd5,
        FN_RDHEX = 3'd6,
        FN_CLR  = 3'd7
    } func_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FINISH
    } state_t;

    // How the datapath formats rdata when it loads a result.
    typedef enum logic [1:0] {
        FMT_ZERO,
        FMT_WORD,
        FMT_HEX
    } fmt_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // latch a new beat
        logic short_now;  // hex read found fewer than two bytes
        logic push;       // write one byte at the tail
        logic pop;        // read one byte at the head
        logic clear;      // reset the pointers and the count
        logic finish;     // load the result register
        fmt_t fmt;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_lt2;
        logic out_free;
    } status_t;

    // Converts one ASCII hex character to its value; other characters pass raw.
    function automatic logic [BYTE_W-1:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = c;
        if (c >= CH_0 && c <= CH_9)
        begin
            v = c - CH_0;
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            v = c - LA_OFS;
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            v = c - UA_OFS;
        end
        return v;
    endfunction

endpackage

// File: sv/obrf_if.sv
// Valid/ready channel interfaces for the operation beats and the result beats.
interface obrf_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [obrf_pkg::FUNC_W-1:0]     func;
    logic [obrf_pkg::DATA_W-1:0]     wdata;

    modport source (output valid, func, wdata, input ready);
    modport sink   (input valid, func, wdata, output ready);
endinterface

interface obrf_res_if;
    logic                            valid;
    logic                            ready;
    logic [obrf_pkg::DATA_W-1:0]     rdata;
    logic                            shortfall;
    logic [obrf_pkg::LEVEL_W-1:0]    fill_level;
    logic [obrf_pkg::LEVEL_W-1:0]    space_left;

    modport source (output valid, rdata, shortfall, fill_level, space_left, input ready);
    modport sink   (input valid, rdata, shortfall, fill_level, space_left, output ready);
endinterface

// File: sv/obrf_ctrl.sv
// Controller state machine: sequences the byte steps of each operation beat.
module obrf_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    input  logic [obrf_pkg::FUNC_W-1:0]  func,
    output logic                         ready,
    input  obrf_pkg::status_t            status,
    output obrf_pkg::cmd_t               cmd
);

    obrf_pkg::state_t state_reg, state_next;
    obrf_pkg::func_t  op_reg, op_next;
    logic [1:0]       left_reg, left_next;

    obrf_pkg::func_t  func_in;
    logic [1:0]       steps_m1;
    logic             no_steps;
    logic             is_write;

    assign func_in = obrf_pkg::func_t'(func);

    // Decode the byte step count of an incoming beat.
    always_comb
    begin
        steps_m1 = 2'd0;
        no_steps = 1'b0;
        unique case (func_in)
            obrf_pkg::FN_WR8, obrf_pkg::FN_RD8:
            begin
                steps_m1 = 2'd0;
            end
            obrf_pkg::FN_WR16, obrf_pkg::FN_RD16:
            begin
                steps_m1 = 2'd1;
            end
            obrf_pkg::FN_WR32, obrf_pkg::FN_RD32:
            begin
                steps_m1 = 2'd3;
            end
            obrf_pkg::FN_RDHEX:
            begin
                steps_m1 = 2'd1;
                no_steps = status.count_lt2;
            end
            obrf_pkg::FN_CLR:
            begin
                no_steps = 1'b1;
            end
            default:
            begin
                no_steps = 1'b1;
            end
        endcase
    end

    assign is_write = (op_reg == obrf_pkg::FN_WR8) || (op_reg == obrf_pkg::FN_WR16)
                   || (op_reg == obrf_pkg::FN_WR32);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        left_next  = left_reg;
        unique case (state_reg)
            obrf_pkg::ST_IDLE:
            begin
                if (valid)
                begin
                    op_next    = func_in;
                    left_next  = steps_m1;
                    state_next = no_steps ? obrf_pkg::ST_FINISH : obrf_pkg::ST_STEP;
                end
            end
            obrf_pkg::ST_STEP:
            begin
                left_next = left_reg - 2'd1;
                if (left_reg == 2'd0)
                begin
                    state_next = obrf_pkg::ST_FINISH;
                end
            end
            obrf_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = obrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = obrf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ready         = 1'b0;
        cmd           = '0;
        cmd.fmt       = obrf_pkg::FMT_ZERO;
        unique case (state_reg)
            obrf_pkg::ST_IDLE:
            begin
                ready         = 1'b1;
                cmd.start     = valid;
                cmd.clear     = valid && (func_in == obrf_pkg::FN_CLR);
                cmd.short_now = valid && (func_in == obrf_pkg::FN_RDHEX) && status.count_lt2;
            end
            obrf_pkg::ST_STEP:
            begin
                cmd.push = is_write;
                cmd.pop  = !is_write;
            end
            obrf_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
                if (op_reg == obrf_pkg::FN_RDHEX)
                begin
                    cmd.fmt = obrf_pkg::FMT_HEX;
                end
                else if ((op_reg == obrf_pkg::FN_RD8) || (op_reg == obrf_pkg::FN_RD16)
                      || (op_reg == obrf_pkg::FN_RD32))
                begin
                    cmd.fmt = obrf_pkg::FMT_WORD;
                end
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obrf_pkg::ST_IDLE;
            op_reg    <= obrf_pkg::FN_WR8;
            left_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            left_reg  <= left_next;
        end
    end

endmodule

// File: sv/obrf_dpath.sv
// Datapath: byte store, ring pointers, fill count, read assembly and result register.
module obrf_dpath
#(
    parameter int DEPTH = obrf_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [obrf_pkg::LEVEL_W-1:0]  cfg_wdata,
    input  logic [obrf_pkg::FUNC_W-1:0]   func,
    input  logic [obrf_pkg::DATA_W-1:0]   wdata,
    input  obrf_pkg::cmd_t                cmd,
    output obrf_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [obrf_pkg::DATA_W-1:0]   rdata,
    output logic                          shortfall,
    output logic [obrf_pkg::LEVEL_W-1:0]  fill_level,
    output logic [obrf_pkg::LEVEL_W-1:0]  space_left
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CMP_W = (PTR_W > obrf_pkg::LEVEL_W) ? PTR_W : obrf_pkg::LEVEL_W;
    localparam int CAP_RESET_EFF =
        (obrf_pkg::CAP_RESET > DEPTH) ? DEPTH : obrf_pkg::CAP_RESET;
    localparam int BW = obrf_pkg::BYTE_W;
    localparam int DW = obrf_pkg::DATA_W;
    localparam int LW = obrf_pkg::LEVEL_W;

    logic [BW-1:0]     store_mem [0:DEPTH-1];

    logic [LW-1:0]     cap_reg, cap_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [LW-1:0]     count_reg, count_next;
    logic [DW-1:0]     wbuf_reg, wbuf_next;
    logic [DW-1:0]     acc_reg, acc_next;
    logic [BW-1:0]     rd_q_reg;
    logic              pend_reg;
    logic              short_reg, short_next;
    logic              out_valid_reg, out_valid_next;
    logic [DW-1:0]     rdata_reg;
    logic              shortfall_reg;
    logic [LW-1:0]     fill_reg;
    logic [LW-1:0]     space_reg;

    logic              pop_ok;
    logic              full;
    logic              head_wrap;
    logic              tail_wrap;
    logic [CMP_W-1:0]  cap_last;
    logic [BW-1:0]     nib_h;
    logic [BW-1:0]     nib_l;
    logic [BW-1:0]     hex_byte;
    logic [DW-1:0]     result;

    assign pop_ok    = cmd.pop && (count_reg != '0);
    assign full      = (count_reg == cap_reg);
    assign cap_last  = CMP_W'(cap_reg - LW'(1));
    assign head_wrap = (CMP_W'(head_reg) == cap_last);
    assign tail_wrap = (CMP_W'(tail_reg) == cap_last);

    // Capacity register holds the effective capacity, limited to 1..DEPTH.
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                cap_next = LW'(1);
            end
            else if (32'(cfg_wdata) > DEPTH)
            begin
                cap_next = LW'(DEPTH);
            end
            else
            begin
                cap_next = cfg_wdata;
            end
        end
    end

    // Pointer and count update for one byte step or a pointer reset.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cfg_we || cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            tail_next = tail_wrap ? '0 : tail_reg + PTR_W'(1);
            if (full)
            begin
                head_next = head_wrap ? '0 : head_reg + PTR_W'(1);
            end
            else
            begin
                count_next = count_reg + LW'(1);
            end
        end
        else if (pop_ok)
        begin
            head_next  = head_wrap ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - LW'(1);
        end
    end

    // Write byte shifter: the next byte to store sits in the top byte.
    always_comb
    begin
        wbuf_next = wbuf_reg;
        if (cmd.start)
        begin
            case (obrf_pkg::func_t'(func))
                obrf_pkg::FN_WR8:  wbuf_next = wdata << 24;
                obrf_pkg::FN_WR16: wbuf_next = wdata << 16;
                default:           wbuf_next = wdata;
            endcase
        end
        else if (cmd.push)
        begin
            wbuf_next = wbuf_reg << 8;
        end
    end

    // Read assembly: a byte read last cycle shifts in big-endian.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start)
        begin
            acc_next = '0;
        end
        else if (pend_reg)
        begin
            acc_next = {acc_reg[DW-BW-1:0], rd_q_reg};
        end
    end

    // Shortfall flag for the beat in progress.
    always_comb
    begin
        short_next = short_reg;
        if (cmd.start)
        begin
            short_next = cmd.short_now;
        end
        else if (cmd.pop && !pop_ok)
        begin
            short_next = 1'b1;
        end
    end

    // Result formatting.
    assign nib_h    = obrf_pkg::hex_nibble(acc_next[2*BW-1:BW]);
    assign nib_l    = obrf_pkg::hex_nibble(acc_next[BW-1:0]);
    assign hex_byte = {nib_h[3:0], 4'b0000} + nib_l;

    always_comb
    begin
        result = '0;
        case (cmd.fmt)
            obrf_pkg::FMT_WORD: result = short_reg ? '1 : acc_next;
            obrf_pkg::FMT_HEX:  result = short_reg ? '1 : DW'(hex_byte);
            default:            result = '0;
        endcase
    end

    // Result register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Byte store: one access per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            store_mem[tail_reg] <= wbuf_reg[DW-1:DW-BW];
        end
        if (pop_ok)
        begin
            rd_q_reg <= store_mem[head_reg];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        wbuf_reg <= wbuf_next;
        acc_reg  <= acc_next;
        if (cmd.finish)
        begin
            rdata_reg     <= result;
            shortfall_reg <= short_reg;
            fill_reg      <= count_reg;
            space_reg     <= cap_reg - count_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= LW'(CAP_RESET_EFF);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            short_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pend_reg      <= pop_ok;
            short_reg     <= short_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.count_lt2 = (count_reg < LW'(2));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign rdata      = rdata_reg;
    assign shortfall  = shortfall_reg;
    assign fill_level = fill_reg;
    assign space_left = space_reg;

endmodule

// File: sv/overwrite_byte_ring_fifo_top.sv
// Top level of the overwrite byte ring FIFO: controller, datapath and channel ports.
//
// A byte ring whose wrap point is the capacity register (0 acts as 1, values above
// DEPTH act as DEPTH); writing capacity also empties the ring. Writes push 1, 2 or 4
// bytes most significant first and overwrite the oldest byte when full; reads pop
// 1, 2 or 4 bytes big-endian, or two ASCII hex characters combined into one byte.
// Each operation beat yields one result beat with the fill level and free space.
// Sequence: each beat is accepted in idle, then its bytes go through byte steps, one
// byte per cycle through the single-port byte store, even when a read runs short.
// The finish state then loads the result register and returns to idle, where the
// next beat is accepted. A pointer reset, or a hex read that finds fewer than two
// bytes, goes from idle straight to the finish state with no byte steps.
// A finished result waits in an output register while the next beat is accepted and
// worked on; that beat holds in its last cycle until the output register is free.
module overwrite_byte_ring_fifo_top
#(
    parameter int DEPTH = obrf_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [obrf_pkg::LEVEL_W-1:0]  cfg_wdata,
    obrf_cmd_if.sink                      cmd_ch,
    obrf_res_if.source                    res_ch
);

    obrf_pkg::cmd_t    cmd;
    obrf_pkg::status_t status;

    // Sequencer for the byte steps.
    obrf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (cmd_ch.valid),
        .func   (cmd_ch.func),
        .ready  (cmd_ch.ready),
        .status (status),
        .cmd    (cmd)
    );

    // Store, pointers and result register.
    obrf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .func       (cmd_ch.func),
        .wdata      (cmd_ch.wdata),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (res_ch.valid),
        .out_ready  (res_ch.ready),
        .rdata      (res_ch.rdata),
        .shortfall  (res_ch.shortfall),
        .fill_level (res_ch.fill_level),
        .space_left (res_ch.space_left)
    );

endmodule

// File: bench/overwrite_byte_ring_fifo_top_tb.sv
// Self-checking testbench for the overwrite byte ring FIFO, with a byte-accurate ring predictor.
`timescale 1ns / 100ps

module overwrite_byte_ring_fifo_top_tb;

    localparam int RING_DEPTH   = obrf_pkg::DEPTH_DEFAULT;
    localparam int REPORT_LIMIT = 10;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 16;

    // One operation beat as queued for the driver.
    typedef struct {
        obrf_pkg::func_t             op;
        logic [obrf_pkg::DATA_W-1:0] data;
    } op_beat_t;

    // One result beat as the block reports it.
    typedef struct packed {
        logic [obrf_pkg::DATA_W-1:0]  rdata;
        logic                         shortfall;
        logic [obrf_pkg::LEVEL_W-1:0] fill_level;
        logic [obrf_pkg::LEVEL_W-1:0] space_left;
    } res_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [obrf_pkg::LEVEL_W-1:0] cfg_wdata = '0;

    // Driver and monitor outputs, known from time zero.
    logic                        op_valid = 1'b0;
    obrf_pkg::func_t             op_func = obrf_pkg::FN_WR8;
    logic [obrf_pkg::DATA_W-1:0] op_wdata = '0;
    logic                        res_ready = 1'b0;

    obrf_cmd_if cmd_ch();
    obrf_res_if res_ch();

    assign cmd_ch.valid = op_valid;
    assign cmd_ch.func  = op_func;
    assign cmd_ch.wdata = op_wdata;
    assign res_ch.ready = res_ready;

    overwrite_byte_ring_fifo_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predicted ring contents and pointers.
    logic [obrf_pkg::BYTE_W-1:0]  ring_bytes [0:RING_DEPTH-1];
    int                           ring_head = 0;
    int                           ring_tail = 0;
    int                           ring_fill = 0;
    logic [obrf_pkg::LEVEL_W-1:0] ring_cap_reg = obrf_pkg::LEVEL_W'(obrf_pkg::CAP_RESET);

    op_beat_t  pending_ops [$];
    res_beat_t due_results [$];
    int        failures = 0;
    int        results_seen = 0;

    // Capacity as the block applies it: zero acts as one, large values clamp to the depth.
    function automatic int ring_cap();
        if (ring_cap_reg == 0)
        begin
            return 1;
        end
        if (ring_cap_reg > RING_DEPTH)
        begin
            return RING_DEPTH;
        end
        return int'(ring_cap_reg);
    endfunction

    function automatic void ring_clear();
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
    endfunction

    // A push into a full ring drops the oldest byte.
    function automatic void push_byte(logic [obrf_pkg::BYTE_W-1:0] b);
        ring_bytes[ring_tail] = b;
        ring_tail++;
        if (ring_tail >= ring_cap())
        begin
            ring_tail = 0;
        end
        ring_fill++;
        if (ring_fill > ring_cap())
        begin
            ring_fill = ring_cap();
            ring_head++;
            if (ring_head >= ring_cap())
            begin
                ring_head = 0;
            end
        end
    endfunction

    function automatic bit pop_byte(output logic [obrf_pkg::BYTE_W-1:0] b);
        b = '0;
        if (ring_fill == 0)
        begin
            return 1'b0;
        end
        b = ring_bytes[ring_head];
        ring_head++;
        if (ring_head >= ring_cap())
        begin
            ring_head = 0;
        end
        ring_fill--;
        return 1'b1;
    endfunction

    // Value of an ASCII hex digit; any other character keeps its raw code.
    function automatic logic [obrf_pkg::BYTE_W-1:0] ascii_value(
        logic [obrf_pkg::BYTE_W-1:0] c);
        if (c >= obrf_pkg::CH_0 && c <= obrf_pkg::CH_9)
        begin
            return c - obrf_pkg::CH_0;
        end
        if (c >= obrf_pkg::CH_LA && c <= obrf_pkg::CH_LF)
        begin
            return c - obrf_pkg::LA_OFS;
        end
        if (c >= obrf_pkg::CH_UA && c <= obrf_pkg::CH_UF)
        begin
            return c - obrf_pkg::UA_OFS;
        end
        return c;
    endfunction

    // Applies one operation to the predicted ring and returns its result beat.
    function automatic res_beat_t ring_step(obrf_pkg::func_t op,
                                            logic [obrf_pkg::DATA_W-1:0] w);
        res_beat_t                   r;
        int                          nbytes;
        int                          i;
        logic [obrf_pkg::BYTE_W-1:0] b;
        logic [obrf_pkg::BYTE_W-1:0] hi;
        logic [obrf_pkg::BYTE_W-1:0] lo;
        logic [obrf_pkg::DATA_W-1:0] word;
        r.rdata = '0;
        r.shortfall = 1'b0;
        case (op)
            obrf_pkg::FN_WR8:
            begin
                push_byte(w[7:0]);
            end
            obrf_pkg::FN_WR16:
            begin
                push_byte(w[15:8]);
                push_byte(w[7:0]);
            end
            obrf_pkg::FN_WR32:
            begin
                push_byte(w[31:24]);
                push_byte(w[23:16]);
                push_byte(w[15:8]);
                push_byte(w[7:0]);
            end
            obrf_pkg::FN_RD8, obrf_pkg::FN_RD16, obrf_pkg::FN_RD32:
            begin
                nbytes = (op == obrf_pkg::FN_RD8) ? 1 : (op == obrf_pkg::FN_RD16) ? 2 : 4;
                word = '0;
                // A short read still drains whatever bytes are there.
                for (i = 0; i < nbytes; i++)
                begin
                    if (pop_byte(b))
                    begin
                        word = {word[obrf_pkg::DATA_W-obrf_pkg::BYTE_W-1:0], b};
                    end
                    else
                    begin
                        r.shortfall = 1'b1;
                    end
                end
                r.rdata = r.shortfall ? '1 : word;
            end
            obrf_pkg::FN_RDHEX:
            begin
                // A hex read with fewer than two bytes consumes nothing.
                if (ring_fill < 2)
                begin
                    r.shortfall = 1'b1;
                    r.rdata = '1;
                end
                else
                begin
                    void'(pop_byte(hi));
                    void'(pop_byte(lo));
                    b = (ascii_value(hi) << 4) + ascii_value(lo);
                    r.rdata = {24'd0, b};
                end
            end
            default:
            begin
                ring_clear();
            end
        endcase
        r.fill_level = obrf_pkg::LEVEL_W'(ring_fill);
        r.space_left = obrf_pkg::LEVEL_W'(ring_cap() - ring_fill);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long; none during a calm stretch.
    function automatic int pick_gap(int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0 || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Half the words are raw; the rest are mostly hex characters so that hex reads decode.
    function automatic logic [obrf_pkg::DATA_W-1:0] rand_word();
        logic [obrf_pkg::DATA_W-1:0] w;
        int                          k;
        int                          r;
        if ($urandom_range(0, 1) == 0)
        begin
            return $urandom();
        end
        for (k = 0; k < 4; k++)
        begin
            r = $urandom_range(0, 24);
            if (r < 10)
            begin
                w = {w[23:0], 8'(obrf_pkg::CH_0 + r)};
            end
            else if (r < 16)
            begin
                w = {w[23:0], 8'(obrf_pkg::CH_LA + r - 10)};
            end
            else if (r < 22)
            begin
                w = {w[23:0], 8'(obrf_pkg::CH_UA + r - 16)};
            end
            else
            begin
                w = {w[23:0], 8'($urandom_range(0, 255))};
            end
        end
        return w;
    endfunction

    function automatic op_beat_t rand_op(int write_pct);
        op_beat_t o;
        int       r;
        o.data = rand_word();
        if ($urandom_range(0, 99) < write_pct)
        begin
            o.op = obrf_pkg::func_t'($urandom_range(0, 2));
        end
        else
        begin
            r = $urandom_range(0, 99);
            o.op = (r < 25) ? obrf_pkg::FN_RD8 :
                   (r < 50) ? obrf_pkg::FN_RD16 :
                   (r < 72) ? obrf_pkg::FN_RD32 :
                   (r < 94) ? obrf_pkg::FN_RDHEX : obrf_pkg::FN_CLR;
        end
        return o;
    endfunction

    task automatic add_op(obrf_pkg::func_t op, logic [obrf_pkg::DATA_W-1:0] data);
        op_beat_t o;
        o.op = op;
        o.data = data;
        pending_ops.push_back(o);
    endtask

    // Waits until every queued beat is sent and every result has come back.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_ops.size() != 0 || op_valid || due_results.size() != 0);
    endtask

    // Writes the capacity while the block is idle; the ring empties as well.
    task automatic write_capacity(logic [obrf_pkg::LEVEL_W-1:0] cap);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        ring_cap_reg = cap;
        ring_clear();
    endtask

    task automatic run_phase(logic [obrf_pkg::LEVEL_W-1:0] cap, int count, int write_pct);
        int i;
        write_capacity(cap);
        for (i = 0; i < count; i++)
        begin
            pending_ops.push_back(rand_op(write_pct));
        end
    endtask

    function automatic void note_failure(string msg);
        if (failures < REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
        failures++;
    endfunction

    // Driver: launches queued operation beats and predicts each one on acceptance.
    int       op_gap = 0;
    int       op_calm = 0;
    op_beat_t next_op;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid <= 1'b0;
            op_gap <= 0;
        end
        else if (!op_valid || cmd_ch.ready)
        begin
            if (op_valid)
            begin
                due_results.push_back(ring_step(op_func, op_wdata));
            end
            if (op_gap > 0)
            begin
                op_gap <= op_gap - 1;
                op_valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                next_op = pending_ops.pop_front();
                op_valid <= 1'b1;
                op_func <= next_op.op;
                op_wdata <= next_op.data;
                op_gap <= pick_gap(op_calm);
                if (op_calm > 0)
                begin
                    op_calm <= op_calm - 1;
                end
                else if ($urandom_range(0, 99) < 4)
                begin
                    op_calm <= 40;
                end
            end
            else
            begin
                op_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls at random and checks each accepted result beat.
    int        res_stall = 0;
    int        res_calm = 0;
    int        res_gap;
    res_beat_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            res_stall <= 0;
        end
        else if (res_ch.valid && res_ready)
        begin
            if (due_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result beat: rdata=%h fill=%0d",
                                       res_ch.rdata, res_ch.fill_level));
            end
            else
            begin
                want = due_results.pop_front();
                if (res_ch.rdata !== want.rdata || res_ch.shortfall !== want.shortfall ||
                    res_ch.fill_level !== want.fill_level ||
                    res_ch.space_left !== want.space_left)
                begin
                    note_failure($sformatf(
                        {"result %0d mismatch: expected rdata=%h short=%0d fill=%0d ",
                         "space=%0d, got rdata=%h short=%0d fill=%0d space=%0d"},
                        results_seen, want.rdata, want.shortfall, want.fill_level,
                        want.space_left, res_ch.rdata, res_ch.shortfall,
                        res_ch.fill_level, res_ch.space_left));
                end
            end
            results_seen <= results_seen + 1;
            res_gap = pick_gap(res_calm);
            res_stall <= res_gap;
            res_ready <= (res_gap == 0);
            if (res_calm > 0)
            begin
                res_calm <= res_calm - 1;
            end
            else if ($urandom_range(0, 99) < 4)
            begin
                res_calm <= 40;
            end
        end
        else if (res_stall > 0)
        begin
            res_stall <= res_stall - 1;
            res_ready <= (res_stall == 1);
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no beat and no register write moves for too long.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (op_valid && cmd_ch.ready) || (res_ch.valid && res_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: reset, directed beats and a random mix, then random phases over several capacities.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reads of an empty ring, including a hex read with a single byte stored.
        add_op(obrf_pkg::FN_RD8, 32'h0);
        add_op(obrf_pkg::FN_RD16, 32'h0);
        add_op(obrf_pkg::FN_RD32, 32'h0);
        add_op(obrf_pkg::FN_RDHEX, 32'h0);
        add_op(obrf_pkg::FN_WR8, 32'hFFFF_FF00);
        add_op(obrf_pkg::FN_RDHEX, 32'h0);
        add_op(obrf_pkg::FN_RD16, 32'h0);
        // All-ones data that must not read as a shortfall.
        add_op(obrf_pkg::FN_WR32, 32'hFFFF_FFFF);
        add_op(obrf_pkg::FN_RD32, 32'h0);
        // Hex pairs in upper case, lower case, and with characters that are not hex.
        add_op(obrf_pkg::FN_WR16, 32'h0000_3946);
        add_op(obrf_pkg::FN_RDHEX, 32'h0);
        add_op(obrf_pkg::FN_WR16, 32'h0000_6130);
        add_op(obrf_pkg::FN_RDHEX, 32'h0);
        add_op(obrf_pkg::FN_WR32, 32'h4766_4B2F);
        add_op(obrf_pkg::FN_RDHEX, 32'h0);
        add_op(obrf_pkg::FN_RDHEX, 32'h0);
        // Byte order and a pointer reset with data still stored.
        add_op(obrf_pkg::FN_WR32, 32'h1234_5678);
        add_op(obrf_pkg::FN_WR8, 32'h0000_009A);
        add_op(obrf_pkg::FN_RD16, 32'h0);
        add_op(obrf_pkg::FN_CLR, 32'hFFFF_FFFF);
        add_op(obrf_pkg::FN_RD8, 32'h0);
        add_op(obrf_pkg::FN_WR32, 32'h0000_0000);
        add_op(obrf_pkg::FN_RD32, 32'h0);
        add_op(obrf_pkg::FN_WR16, 32'h0000_FFFF);
        add_op(obrf_pkg::FN_RD8, 32'h0);
        for (int i = 0; i < 80; i++)
        begin
            pending_ops.push_back(rand_op(55));
        end

        // Write-heavy full capacity so the ring fills and overwrites.
        run_phase(9'd256, 150, 85);
        run_phase(9'd1, 40, 50);
        run_phase(9'd0, 30, 50);
        run_phase(9'd2, 40, 50);
        run_phase(9'd3, 40, 55);
        run_phase(9'd511, 40, 60);
        run_phase(9'd257, 30, 60);
        run_phase(9'd5, 40, 50);
        run_phase(obrf_pkg::LEVEL_W'($urandom_range(1, 300)), 40, 55);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && due_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
